>>> sv/tpq_pkg.sv
// tpq_pkg: shared types, constants and the control program of the touch pressure qualifier
// no dependencies; used by touch_pressure_qualifier_unit by scoped names
`default_nettype none

package tpq_pkg;

   // register file
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 16;

   localparam logic [CsrIndexWidth-1:0] CSR_DEBOUNCE_ENABLE  = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_DEBOUNCE_REPORTS = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_PRESSURE_MIN     = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_PRESSURE_MAX     = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_PLATE_SCALE      = 3'd4;

   localparam logic [7:0]  DebounceReportsReset = 8'd5;
   localparam logic [9:0]  PressureMinReset     = 10'd300;
   localparam logic [9:0]  PressureMaxReset     = 10'd900;
   localparam logic [15:0] PlateScaleReset      = 16'd750;

   // pressure formula constants
   localparam logic [31:0] RoundBias    = 32'd2047;
   localparam int          RoundShift   = 12;
   localparam logic [31:0] PressureFull = 32'd1000;
   localparam logic [7:0]  PenUpCode    = 8'd1;

   // serial divider: one quotient bit per step
   localparam int          DivBits    = 32;
   localparam int          DivCntWidth = $clog2(DivBits);
   localparam logic [DivCntWidth-1:0] DivCntStart = DivCntWidth'(DivBits - 1);

   typedef struct packed {
      logic [15:0] x_raw;
      logic [15:0] y_raw;
      logic [15:0] z1_raw;
      logic [15:0] z2_raw;
      logic [7:0]  pen_flag;
   } req_type;

   typedef struct packed {
      logic [14:0] x_pos;
      logic [14:0] y_pos;
      logic [9:0]  pressure;
      logic        touched;
      logic        has_position;
   } rsp_type;

   // sequencer
   typedef logic [2:0] step_type;

   localparam step_type STEP_IDLE   = 3'd0;
   localparam step_type STEP_SUB    = 3'd1;
   localparam step_type STEP_MULX   = 3'd2;
   localparam step_type STEP_MULS   = 3'd3;
   localparam step_type STEP_DIVI   = 3'd4;
   localparam step_type STEP_DIVS   = 3'd5;
   localparam step_type STEP_ROUND  = 3'd6;
   localparam step_type STEP_DECIDE = 3'd7;

   typedef enum logic [2:0] {
      OP_WAIT,
      OP_SUB,
      OP_MULX,
      OP_MULS,
      OP_DIVI,
      OP_DIVS,
      OP_ROUND,
      OP_DECIDE
   } op_type;

   typedef enum logic [1:0] {
      COND_NEXT,   // go to target
      COND_REQ,    // go to target once a transaction is accepted
      COND_LOOP,   // stay while divider count is nonzero
      COND_OUT     // go to target once the output register is free
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_word_type;

   function automatic ctrl_word_type ctrl_rom(input step_type s);
      ctrl_word_type w;
      case (s)
         STEP_IDLE:   w = '{op: OP_WAIT,   cond: COND_REQ,  target: STEP_SUB};
         STEP_SUB:    w = '{op: OP_SUB,    cond: COND_NEXT, target: STEP_MULX};
         STEP_MULX:   w = '{op: OP_MULX,   cond: COND_NEXT, target: STEP_MULS};
         STEP_MULS:   w = '{op: OP_MULS,   cond: COND_NEXT, target: STEP_DIVI};
         STEP_DIVI:   w = '{op: OP_DIVI,   cond: COND_NEXT, target: STEP_DIVS};
         STEP_DIVS:   w = '{op: OP_DIVS,   cond: COND_LOOP, target: STEP_ROUND};
         STEP_ROUND:  w = '{op: OP_ROUND,  cond: COND_NEXT, target: STEP_DECIDE};
         STEP_DECIDE: w = '{op: OP_DECIDE, cond: COND_OUT,  target: STEP_IDLE};
         default:     w = '{op: OP_WAIT,   cond: COND_REQ,  target: STEP_SUB};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

>>> sv/touch_pressure_qualifier_unit.sv
// touch_pressure_qualifier_unit: top level, microcoded sequencer with shared datapath
// depends on tpq_pkg (types, register codes, control program)
`default_nettype none

// Qualifies one resistive touch report per transaction. The raw x, y, z1 and z2
// words are halved, z1 is forced to one when zero, and a touch resistance
// ((z2-z1)*x*plate_scale/z1 + 2047) >> 12 is formed in 32-bit wrapping arithmetic
// and subtracted from 1000; a value outside [pressure_min, pressure_max] becomes
// zero. A report gives at most one response transaction. The control program runs
// 39 steps per report: one accept step, three arithmetic steps, a divider setup step,
// 32 steps of the bit-serial restoring divider, a rounding step and a decision step.
// Any response is loaded in the decision step, and no new report is accepted before
// the last one has passed it. A new report is taken as soon as the sequencer is back
// in its idle step, even while the last response still waits in the output register;
// the decision step holds only while that register is full and not being taken. The
// csr port is always ready and writes should be made while the block is idle.
module touch_pressure_qualifier_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output      logic                                req_ready,
   input  wire tpq_pkg::req_type                    req_data,
   // response channel
   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output      tpq_pkg::rsp_type                    rsp_data,
   // configuration write channel
   input  wire logic                                csr_valid,
   output      logic                                csr_ready,
   input  wire logic [tpq_pkg::CsrIndexWidth-1:0]   csr_index,
   input  wire logic [tpq_pkg::CsrDataWidth-1:0]    csr_data
);

   // configuration registers
   logic        deb_en_ff;
   logic [7:0]  deb_reports_ff;
   logic [9:0]  p_min_ff;
   logic [9:0]  p_max_ff;
   logic [15:0] scale_ff;

   // sequencer
   tpq_pkg::step_type      step_ff, step_in;
   tpq_pkg::ctrl_word_type cw;
   logic                   go;
   logic                   slot_free;

   // latched report
   logic [14:0] x_ff, x_in;
   logic [14:0] y_ff, y_in;
   logic [14:0] z1_ff, z1_in;
   logic [14:0] z2_ff, z2_in;
   logic        up_ff, up_in;

   // datapath
   logic [31:0] acc_ff, acc_in;
   logic [31:0] quo_ff, quo_in;
   logic [14:0] rem_ff, rem_in;
   logic [tpq_pkg::DivCntWidth-1:0] cnt_ff, cnt_in;
   logic [9:0]  p_ff, p_in;

   // pen state
   logic        pen_ff, pen_in;
   logic [7:0]  left_ff, left_in;

   // output register
   tpq_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   assign cw        = tpq_pkg::ctrl_rom(step_ff);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (cw.op == tpq_pkg::OP_WAIT);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // step counter and conditional jumps
   always_comb begin
      case (cw.cond)
         tpq_pkg::COND_NEXT: go = 1'b1;
         tpq_pkg::COND_REQ:  go = req_valid;
         tpq_pkg::COND_LOOP: go = (cnt_ff == '0);
         tpq_pkg::COND_OUT:  go = slot_free;
         default:            go = 1'b1;
      endcase
      step_in = go ? cw.target : step_ff;
   end

   // datapath driven by the control word
   always_comb begin
      logic [15:0] z1_half;
      logic [15:0] rem_sh;
      logic        qbit;
      logic [31:0] sum;
      logic [31:0] r;
      logic        in_window;
      logic        emit;
      logic [7:0]  left_dec;

      x_in         = x_ff;
      y_in         = y_ff;
      z1_in        = z1_ff;
      z2_in        = z2_ff;
      up_in        = up_ff;
      acc_in       = acc_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      p_in         = p_ff;
      pen_in       = pen_ff;
      left_in      = left_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      z1_half   = {1'b0, req_data.z1_raw[15:1]};
      rem_sh    = {rem_ff, quo_ff[31]};
      qbit      = (rem_sh >= {1'b0, z1_ff});
      sum       = quo_ff + tpq_pkg::RoundBias;
      r         = tpq_pkg::PressureFull - (sum >> tpq_pkg::RoundShift);
      in_window = (r <= {22'b0, p_max_ff}) && (r >= {22'b0, p_min_ff});
      emit      = 1'b0;
      left_dec  = (left_ff != '0) ? left_ff - 8'd1 : 8'd0;

      case (cw.op)
         tpq_pkg::OP_WAIT: begin
            if (go) begin
               x_in  = req_data.x_raw[15:1];
               y_in  = req_data.y_raw[15:1];
               z1_in = (z1_half == '0) ? 15'd1 : z1_half[14:0];
               z2_in = req_data.z2_raw[15:1];
               up_in = (req_data.pen_flag == tpq_pkg::PenUpCode);
            end
         end
         tpq_pkg::OP_SUB:  acc_in = {17'b0, z2_ff} - {17'b0, z1_ff};
         tpq_pkg::OP_MULX: acc_in = acc_ff * {17'b0, x_ff};
         tpq_pkg::OP_MULS: acc_in = acc_ff * {16'b0, scale_ff};
         tpq_pkg::OP_DIVI: begin
            quo_in = acc_ff;
            rem_in = '0;
            cnt_in = tpq_pkg::DivCntStart;
         end
         tpq_pkg::OP_DIVS: begin
            // restoring step: remainder stays below z1, so 15 bits hold it
            rem_in = qbit ? 15'(rem_sh - {1'b0, z1_ff}) : rem_sh[14:0];
            quo_in = {quo_ff[30:0], qbit};
            cnt_in = cnt_ff - 1'b1;
         end
         tpq_pkg::OP_ROUND: p_in = in_window ? r[9:0] : 10'd0;
         tpq_pkg::OP_DECIDE: begin
            if (go && !(p_ff == '0 && !up_ff)) begin
               if (!deb_en_ff) begin
                  emit = 1'b1;
               end else if (up_ff == !pen_ff) begin
                  // report agrees with pen state
                  left_in = deb_reports_ff;
                  emit    = !up_ff;
               end else begin
                  left_in = left_dec;
                  if (left_dec == '0) begin
                     pen_in = !up_ff;
                     emit   = 1'b1;
                  end
               end
            end
            if (emit) begin
               rsp_valid_in         = 1'b1;
               rsp_in.x_pos         = up_ff ? 15'd0 : x_ff;
               rsp_in.y_pos         = up_ff ? 15'd0 : y_ff;
               rsp_in.pressure      = p_ff;
               rsp_in.touched       = !up_ff;
               rsp_in.has_position  = !up_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff        <= tpq_pkg::STEP_IDLE;
         rsp_valid_ff   <= 1'b0;
         pen_ff         <= 1'b0;
         left_ff        <= tpq_pkg::DebounceReportsReset;
         deb_en_ff      <= 1'b0;
         deb_reports_ff <= tpq_pkg::DebounceReportsReset;
         p_min_ff       <= tpq_pkg::PressureMinReset;
         p_max_ff       <= tpq_pkg::PressureMaxReset;
         scale_ff       <= tpq_pkg::PlateScaleReset;
         cnt_ff         <= '0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         pen_ff       <= pen_in;
         left_ff      <= left_in;
         cnt_ff       <= cnt_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               tpq_pkg::CSR_DEBOUNCE_ENABLE:  deb_en_ff      <= csr_data[0];
               tpq_pkg::CSR_DEBOUNCE_REPORTS: deb_reports_ff <= csr_data[7:0];
               tpq_pkg::CSR_PRESSURE_MIN:     p_min_ff       <= csr_data[9:0];
               tpq_pkg::CSR_PRESSURE_MAX:     p_max_ff       <= csr_data[9:0];
               tpq_pkg::CSR_PLATE_SCALE:      scale_ff       <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      z1_ff  <= z1_in;
      z2_ff  <= z2_in;
      up_ff  <= up_in;
      acc_ff <= acc_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      p_ff   <= p_in;
      rsp_ff <= rsp_in;
   end

   // a report is taken only from the idle step, never twice in a row
   a_one_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted outside idle step");

   // divider leaves a remainder below the divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      step_ff == tpq_pkg::STEP_ROUND |-> rem_ff < z1_ff)
      else $error("divider remainder not below divisor");

   // pen state changes only in the decision step
   a_pen_change: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(pen_ff) |-> $past(step_ff) == tpq_pkg::STEP_DECIDE)
      else $error("pen state changed outside decision step");

   // a response appears only from the decision step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $rose(rsp_valid_ff) |-> $past(step_ff) == tpq_pkg::STEP_DECIDE)
      else $error("response raised outside decision step");

endmodule

`default_nettype wire
